FILE: src/rblm_pkg.sv
package rblm_pkg;

  localparam int unsigned IDX_OUT_W = 3;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned STATUS_W  = 3;

  // Event codes.
  localparam logic [FUNC_W-1:0] FUNC_START   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DONE    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ACQUIRE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_STOP    = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOFREE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOREADY = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DMAERR  = 3'd5;

  localparam logic [LEN_W-1:0] BUFFER_SIZE_RESET = 16'd2048;

  // Outcome of one round-robin search.
  typedef struct packed {
    logic                 done;
    logic                 found;
    logic [IDX_OUT_W-1:0] idx;
  } scan_res_t;

endpackage

FILE: src/rblm_scan.sv
module rblm_scan #(
  parameter int unsigned BUFFERS = 4
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         start_i,
  input  logic [((BUFFERS > 1) ? $clog2(BUFFERS) : 1)-1:0] base_i,
  input  logic [BUFFERS-1:0]                           want_i,
  output rblm_pkg::scan_res_t                          res_o
);
  import rblm_pkg::*;

  localparam int unsigned IDX_W = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(BUFFERS - 1);

  logic               busy_q;
  logic [IDX_W-1:0]   cand_q;
  logic [IDX_W-1:0]   cnt_q;
  logic [BUFFERS-1:0] want_q;
  scan_res_t          res_q;

  // One candidate is checked per cycle, starting at the base and wrapping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cand_q      <= '0;
      cnt_q       <= '0;
      want_q      <= '0;
      res_q.done  <= 1'b0;
      res_q.found <= 1'b0;
      res_q.idx   <= '0;
    end else begin
      res_q.done <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cand_q <= base_i;
        cnt_q  <= '0;
        want_q <= want_i;
      end else if (busy_q) begin
        if (want_q[cand_q]) begin
          busy_q      <= 1'b0;
          res_q.done  <= 1'b1;
          res_q.found <= 1'b1;
          res_q.idx   <= IDX_OUT_W'(cand_q);
        end else if (cnt_q == LAST) begin
          busy_q      <= 1'b0;
          res_q.done  <= 1'b1;
          res_q.found <= 1'b0;
          res_q.idx   <= '0;
        end else begin
          cand_q <= (cand_q == LAST) ? '0 : cand_q + 1'b1;
          cnt_q  <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign res_o = res_q;

  a_found_wanted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && want_q[cand_q]) |=> (res_q.done && res_q.found))
    else $error("scan missed a wanted candidate");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.done |-> $past(busy_q))
    else $error("scan result without a running search");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q == LAST) |=> (res_q.done && !busy_q))
    else $error("scan ran past the last candidate");

endmodule

FILE: src/rx_buffer_ring_lease_manager.sv
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_ready_o  | func_i, xfer_len_i, length_fetch_error_i,
//         |           |                          | start_refused_i, release_index_i
// out     | output    | out_valid_o / out_ready_i| status_o, frame_serviced_o, frame_stored_o,
//         |           |                          | armed_o, armed_index_o, acquired_index_o,
//         |           |                          | acquired_length_o
// cfg     | input     | cfg_we_i (no wait)       | cfg_wdata_i (buffer size)
//
// An event that needs no search loads its result registers at accept and goes to S_FINISH.
// Start, transfer done, acquire and release with a search pass S_SCAN_GO, S_SCAN_WAIT and
// S_FINISH, while the shared scan unit checks 1 to BUFFERS ring entries, one per cycle.
// One event is in work at a time; the next beat is taken while a result waits on out.
// Reset clears all marks, lengths, pointers and sets buffer size to 2048; no sweep follows.
// A stalled out channel holds the finished result and the sequencer in its final state.
module rx_buffer_ring_lease_manager #(
  parameter int unsigned BUFFERS = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [rblm_pkg::FUNC_W-1:0]        func_i,
  input  logic [rblm_pkg::LEN_W-1:0]         xfer_len_i,
  input  logic                               length_fetch_error_i,
  input  logic                               start_refused_i,
  input  logic [rblm_pkg::IDX_OUT_W-1:0]     release_index_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rblm_pkg::STATUS_W-1:0]      status_o,
  output logic                               frame_serviced_o,
  output logic                               frame_stored_o,
  output logic                               armed_o,
  output logic [rblm_pkg::IDX_OUT_W-1:0]     armed_index_o,
  output logic [rblm_pkg::IDX_OUT_W-1:0]     acquired_index_o,
  output logic [rblm_pkg::LEN_W-1:0]         acquired_length_o,
  input  logic                               cfg_we_i,
  input  logic [rblm_pkg::LEN_W-1:0]         cfg_wdata_i
);
  import rblm_pkg::*;

  localparam int unsigned IDX_W = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(BUFFERS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN_GO,
    S_SCAN_WAIT,
    S_FINISH
  } state_e;

  state_e               state_q;
  logic [LEN_W-1:0]     bsize_q;
  logic [BUFFERS-1:0]   ready_q;
  logic [BUFFERS-1:0]   leased_q;
  logic [LEN_W-1:0]     len_q [BUFFERS];
  logic [IDX_W-1:0]     act_q;
  logic [IDX_W-1:0]     arm_ptr_q;
  logic [IDX_W-1:0]     cons_ptr_q;
  logic                 active_q;
  logic [FUNC_W-1:0]    func_q;
  logic                 refused_q;

  logic [STATUS_W-1:0]  res_status_q;
  logic                 res_serviced_q;
  logic                 res_stored_q;
  logic                 res_armed_q;
  logic [IDX_OUT_W-1:0] res_aidx_q;
  logic [IDX_OUT_W-1:0] res_qidx_q;
  logic [LEN_W-1:0]     res_qlen_q;

  logic                 out_valid_q;
  logic [STATUS_W-1:0]  out_status_q;
  logic                 out_serviced_q;
  logic                 out_stored_q;
  logic                 out_armed_q;
  logic [IDX_OUT_W-1:0] out_aidx_q;
  logic [IDX_OUT_W-1:0] out_qidx_q;
  logic [LEN_W-1:0]     out_qlen_q;

  logic                 in_fire;
  logic                 is_acquire;
  logic [IDX_W-1:0]     scan_base;
  logic [BUFFERS-1:0]   scan_want;
  scan_res_t            scan_res;
  logic [IDX_W-1:0]     hit;
  logic [IDX_W-1:0]     rel;
  logic                 rel_bad;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_acquire = (func_q == FUNC_ACQUIRE);
  assign scan_base  = is_acquire ? cons_ptr_q : arm_ptr_q;
  assign scan_want  = is_acquire ? ready_q : ~(ready_q | leased_q);
  assign hit        = scan_res.idx[IDX_W-1:0];
  assign rel        = release_index_i[IDX_W-1:0];
  assign rel_bad    = ({1'b0, release_index_i} >= (IDX_OUT_W + 1)'(BUFFERS)) || !leased_q[rel];

  rblm_scan #(
    .BUFFERS (BUFFERS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_SCAN_GO),
    .base_i  (scan_base),
    .want_i  (scan_want),
    .res_o   (scan_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      bsize_q        <= BUFFER_SIZE_RESET;
      ready_q        <= '0;
      leased_q       <= '0;
      for (int i = 0; i < BUFFERS; i++) len_q[i] <= '0;
      act_q          <= '0;
      arm_ptr_q      <= '0;
      cons_ptr_q     <= '0;
      active_q       <= 1'b0;
      func_q         <= FUNC_START;
      refused_q      <= 1'b0;
      res_status_q   <= ST_OK;
      res_serviced_q <= 1'b0;
      res_stored_q   <= 1'b0;
      res_armed_q    <= 1'b0;
      res_aidx_q     <= '0;
      res_qidx_q     <= '0;
      res_qlen_q     <= '0;
      out_valid_q    <= 1'b0;
      out_status_q   <= ST_OK;
      out_serviced_q <= 1'b0;
      out_stored_q   <= 1'b0;
      out_armed_q    <= 1'b0;
      out_aidx_q     <= '0;
      out_qidx_q     <= '0;
      out_qlen_q     <= '0;
    end else begin
      if (cfg_we_i) bsize_q <= cfg_wdata_i;
      if (out_valid_q && out_ready_i && state_q != S_FINISH) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            func_q         <= func_i;
            refused_q      <= start_refused_i;
            res_status_q   <= ST_OK;
            res_serviced_q <= 1'b0;
            res_stored_q   <= 1'b0;
            res_armed_q    <= 1'b0;
            res_aidx_q     <= '0;
            res_qidx_q     <= '0;
            res_qlen_q     <= '0;
            state_q        <= S_FINISH;
            case (func_i)
              FUNC_START: begin
                if (active_q) res_status_q <= ST_BUSY;
                else state_q <= S_SCAN_GO;
              end
              FUNC_DONE: begin
                if (active_q) begin
                  if (length_fetch_error_i) begin
                    res_status_q <= ST_DMAERR;
                  end else begin
                    // The frame is consumed; keep it only if it is nonzero and fits the buffer.
                    active_q       <= 1'b0;
                    res_serviced_q <= 1'b1;
                    if (xfer_len_i != '0 && xfer_len_i <= bsize_q) begin
                      len_q[act_q]   <= xfer_len_i;
                      ready_q[act_q] <= 1'b1;
                      res_stored_q   <= 1'b1;
                    end
                    state_q <= S_SCAN_GO;
                  end
                end
              end
              FUNC_ACQUIRE: state_q <= S_SCAN_GO;
              FUNC_RELEASE: begin
                if (rel_bad) begin
                  res_status_q <= ST_INVALID;
                end else begin
                  leased_q[rel] <= 1'b0;
                  len_q[rel]    <= '0;
                  if (!active_q) state_q <= S_SCAN_GO;
                end
              end
              FUNC_STOP: begin
                active_q <= 1'b0;
                ready_q  <= '0;
                leased_q <= '0;
                for (int i = 0; i < BUFFERS; i++) len_q[i] <= '0;
              end
              default: res_status_q <= ST_INVALID;
            endcase
          end
        end
        S_SCAN_GO: state_q <= S_SCAN_WAIT;
        S_SCAN_WAIT: begin
          if (scan_res.done) begin
            state_q <= S_FINISH;
            if (is_acquire) begin
              if (scan_res.found) begin
                ready_q[hit]  <= 1'b0;
                leased_q[hit] <= 1'b1;
                cons_ptr_q    <= (hit == LAST) ? '0 : hit + 1'b1;
                res_qidx_q    <= scan_res.idx;
                res_qlen_q    <= len_q[hit];
              end else begin
                res_status_q <= ST_NOREADY;
              end
            end else if (scan_res.found) begin
              if (refused_q) begin
                res_status_q <= ST_DMAERR;
              end else begin
                act_q       <= hit;
                arm_ptr_q   <= (hit == LAST) ? '0 : hit + 1'b1;
                active_q    <= 1'b1;
                res_armed_q <= 1'b1;
                res_aidx_q  <= scan_res.idx;
              end
            end else if (func_q == FUNC_START) begin
              res_status_q <= ST_NOFREE;
            end
          end
        end
        S_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q    <= 1'b1;
            out_status_q   <= res_status_q;
            out_serviced_q <= res_serviced_q;
            out_stored_q   <= res_stored_q;
            out_armed_q    <= res_armed_q;
            out_aidx_q     <= res_aidx_q;
            out_qidx_q     <= res_qidx_q;
            out_qlen_q     <= res_qlen_q;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign frame_serviced_o  = out_serviced_q;
  assign frame_stored_o    = out_stored_q;
  assign armed_o           = out_armed_q;
  assign armed_index_o     = out_aidx_q;
  assign acquired_index_o  = out_qidx_q;
  assign acquired_length_o = out_qlen_q;

  a_marks_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ready_q & leased_q) == '0)
    else $error("buffer both ready and leased");

  a_active_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> !(ready_q[act_q] || leased_q[act_q]))
    else $error("active transfer targets an occupied buffer");

  a_scan_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_res.done |-> (state_q == S_SCAN_WAIT))
    else $error("scan result outside of the wait state");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != S_IDLE))
    else $error("sequencer stayed idle after a beat");

endmodule
